/* src/dtbl_pkg.sv */
// shared types, codes and constants of the dual token bucket limiter
`default_nettype none

package dtbl_pkg;

   // field widths
   localparam int RATE_BITS_DEFAULT = 20;
   localparam int MODE_BITS         = 2;
   localparam int TIME_BITS         = 32;
   localparam int COUNT_BITS        = 12;
   localparam int STATUS_BITS       = 3;
   localparam int LEFT_BITS         = 20;
   localparam int CSR_INDEX_BITS    = 2;

   // token arithmetic
   localparam int MILLI          = 1000;
   localparam int MAX_ELAPSED_MS = 1000;
   localparam int ELAPSED_BITS   = 10;
   localparam int NEED_BITS      = COUNT_BITS + ELAPSED_BITS;

   // reset rates
   localparam int RESET_MSG_RATE = 100;
   localparam int RESET_PT_RATE  = 500;

   // divide by 1000: drop 3 bits, then multiply by the reciprocal of 125
   localparam int          DIV_PRE_SHIFT = 3;
   localparam int          DIV_IN_BITS   = 31;
   localparam int          DIV_SHIFT     = 38;
   localparam int          DIV_PROD_BITS = DIV_IN_BITS + 32;
   localparam logic [31:0] DIV_RECIP     = 32'd2199023256;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request modes
   localparam logic [MODE_BITS-1:0] MODE_SEND   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REFUND = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RELOAD = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_GRANTED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_LINK   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_MSG_SHORT = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_PT_SHORT  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMITING = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MSG_RATE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PT_RATE  = 2'd2;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_DENY,
      OP_PASS,
      OP_CHARGE,
      OP_REFUND,
      OP_RELOAD,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [TIME_BITS-1:0]    now_ms;
      logic                    telemetry;
      logic [COUNT_BITS-1:0]   point_count;
   } cmd_type;

endpackage

`default_nettype wire

/* src/dtbl_front.sv */
// front end: accepts requests and classifies them into bucket operations
`default_nettype none

module dtbl_front (
   input  wire logic                              limiting_enabled,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dtbl_pkg::MODE_BITS-1:0]    req_mode,
   input  wire logic [dtbl_pkg::TIME_BITS-1:0]    req_now_ms,
   input  wire logic                              req_link_up,
   input  wire logic                              req_limited_topic,
   input  wire logic                              req_telemetry_topic,
   input  wire logic [dtbl_pkg::COUNT_BITS-1:0]   req_point_count,
   input  wire logic                              queue_full,
   output logic                                   push,
   output dtbl_pkg::cmd_type                      cmd
);

   logic active;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;
   assign active    = limiting_enabled && req_limited_topic;

   always_comb begin
      cmd.now_ms      = req_now_ms;
      cmd.telemetry   = req_telemetry_topic;
      cmd.point_count = req_point_count;
      unique case (req_mode)
         dtbl_pkg::MODE_SEND: begin
            if (!req_link_up) begin
               cmd.op = dtbl_pkg::OP_DENY;
            end else if (!active) begin
               cmd.op = dtbl_pkg::OP_PASS;
            end else begin
               cmd.op = dtbl_pkg::OP_CHARGE;
            end
         end
         dtbl_pkg::MODE_REFUND: begin
            cmd.op = active ? dtbl_pkg::OP_REFUND : dtbl_pkg::OP_NONE;
         end
         dtbl_pkg::MODE_RELOAD: begin
            cmd.op = dtbl_pkg::OP_RELOAD;
         end
         default: begin
            cmd.op = dtbl_pkg::OP_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/dtbl_queue.sv */
// two-word queue between the front end and the bucket engine
`default_nettype none

module dtbl_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dtbl_pkg::cmd_type  push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    q_valid,
   output dtbl_pkg::cmd_type       q_cmd
);

   localparam int PTR_BITS = $clog2(dtbl_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(dtbl_pkg::QUEUE_DEPTH + 1);

   dtbl_pkg::cmd_type      entry_ff [dtbl_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;

   assign full    = count_ff == CNT_BITS'(dtbl_pkg::QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // last word popped with nothing arriving leaves the queue empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && count_ff == CNT_BITS'(1)) |=> !q_valid)
      else $error("queue not empty after last word popped");

endmodule

`default_nettype wire

/* src/dtbl_engine.sv */
// back end: bucket state update, divide by 1000 and output register
`default_nettype none

module dtbl_engine #(
   parameter int RATE_BITS = dtbl_pkg::RATE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [RATE_BITS-1:0]                msg_rate,
   input  wire logic [RATE_BITS-1:0]                pt_rate,
   input  wire logic                                q_valid,
   input  wire dtbl_pkg::cmd_type                   cmd,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_granted,
   output logic [dtbl_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [dtbl_pkg::LEFT_BITS-1:0]           rsp_message_tokens_left,
   output logic [dtbl_pkg::LEFT_BITS-1:0]           rsp_point_tokens_left
);

   localparam int MW = RATE_BITS + dtbl_pkg::ELAPSED_BITS;
   localparam int CW = (MW > dtbl_pkg::NEED_BITS) ? MW : dtbl_pkg::NEED_BITS;
   localparam int TW = dtbl_pkg::TIME_BITS;
   localparam int LW = dtbl_pkg::LEFT_BITS;

   // bucket state
   logic [MW-1:0]  msg_milli_ff, msg_milli_in;
   logic [TW-1:0]  msg_last_ff, msg_last_in;
   logic [MW-1:0]  pt_milli_ff, pt_milli_in;
   logic [TW-1:0]  pt_last_ff, pt_last_in;

   // execute stage
   logic                            s1_valid_ff;
   logic                            s1_granted_ff, granted_in;
   logic [dtbl_pkg::STATUS_BITS-1:0] s1_status_ff, status_in;
   logic [MW-1:0]                   s1_msg_ff;
   logic [MW-1:0]                   s1_pt_ff;

   // output stage
   logic                            rsp_valid_ff;
   logic                            rsp_granted_ff;
   logic [dtbl_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [LW-1:0]                   rsp_msg_left_ff;
   logic [LW-1:0]                   rsp_pt_left_ff;

   logic s1_ready;
   logic s2_ready;

   logic [MW-1:0]  cap_msg;
   logic [MW-1:0]  cap_pt;
   logic [MW-1:0]  msg_refilled;
   logic [MW-1:0]  pt_refilled;
   logic           msg_adv;
   logic           pt_adv;
   logic [CW-1:0]  need_pt;
   logic           msg_ok;
   logic           pt_ok;
   logic [MW-1:0]  msg_back;
   logic [MW-1:0]  msg_take;
   logic [MW:0]    msg_refund_sum;
   logic [MW-1:0]  msg_refund;

   logic [dtbl_pkg::DIV_IN_BITS-1:0]   msg_div_in;
   logic [dtbl_pkg::DIV_IN_BITS-1:0]   pt_div_in;
   logic [dtbl_pkg::DIV_PROD_BITS-1:0] msg_prod;
   logic [dtbl_pkg::DIV_PROD_BITS-1:0] pt_prod;

   // elapsed time refill, clamped to one second, capped only when time advanced
   function automatic logic [MW-1:0] refill(
      input logic [MW-1:0]        milli,
      input logic [TW-1:0]        last,
      input logic [RATE_BITS-1:0] rate,
      input logic [MW-1:0]        cap,
      input logic [TW-1:0]        now
   );
      logic [TW-1:0]                     elapsed;
      logic [dtbl_pkg::ELAPSED_BITS-1:0] el;
      logic [MW-1:0]                     add;
      logic [MW:0]                       sum;
      elapsed = now - last;
      el = (elapsed > TW'(dtbl_pkg::MAX_ELAPSED_MS)) ?
           dtbl_pkg::ELAPSED_BITS'(dtbl_pkg::MAX_ELAPSED_MS) :
           elapsed[dtbl_pkg::ELAPSED_BITS-1:0];
      add = MW'(el) * MW'(rate);
      sum = {1'b0, milli} + (MW+1)'(add);
      if (now > last) begin
         refill = (sum > {1'b0, cap}) ? cap : sum[MW-1:0];
      end else begin
         refill = milli;
      end
   endfunction

   assign s2_ready = !rsp_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign pop      = q_valid && s1_ready;

   assign cap_msg = MW'(msg_rate) * MW'(dtbl_pkg::MILLI);
   assign cap_pt  = MW'(pt_rate) * MW'(dtbl_pkg::MILLI);

   assign msg_refilled = refill(msg_milli_ff, msg_last_ff, msg_rate, cap_msg, cmd.now_ms);
   assign pt_refilled  = refill(pt_milli_ff, pt_last_ff, pt_rate, cap_pt, cmd.now_ms);
   assign msg_adv      = cmd.now_ms > msg_last_ff;
   assign pt_adv       = cmd.now_ms > pt_last_ff;

   assign need_pt  = CW'(cmd.point_count) * CW'(dtbl_pkg::MILLI);
   assign msg_ok   = CW'(msg_refilled) >= CW'(dtbl_pkg::MILLI);
   assign pt_ok    = CW'(pt_refilled) >= need_pt;
   assign msg_take = msg_refilled - MW'(dtbl_pkg::MILLI);
   // token given back: refilled level, capped
   assign msg_back = (msg_refilled > cap_msg) ? cap_msg : msg_refilled;

   assign msg_refund_sum = {1'b0, msg_milli_ff} + (MW+1)'(dtbl_pkg::MILLI);
   assign msg_refund     = (msg_refund_sum > {1'b0, cap_msg}) ? cap_msg :
                           msg_refund_sum[MW-1:0];

   always_comb begin
      msg_milli_in = msg_milli_ff;
      msg_last_in  = msg_last_ff;
      pt_milli_in  = pt_milli_ff;
      pt_last_in   = pt_last_ff;
      granted_in   = 1'b0;
      status_in    = dtbl_pkg::STATUS_DONE;
      if (q_valid) begin
         unique case (cmd.op)
            dtbl_pkg::OP_DENY: begin
               status_in = dtbl_pkg::STATUS_NO_LINK;
            end
            dtbl_pkg::OP_PASS: begin
               granted_in = 1'b1;
               status_in  = dtbl_pkg::STATUS_GRANTED;
            end
            dtbl_pkg::OP_CHARGE: begin
               if (msg_adv) begin
                  msg_last_in = cmd.now_ms;
               end
               if (!msg_ok) begin
                  msg_milli_in = msg_refilled;
                  status_in    = dtbl_pkg::STATUS_MSG_SHORT;
               end else if (cmd.telemetry && !pt_ok) begin
                  msg_milli_in = msg_back;
                  pt_milli_in  = pt_refilled;
                  if (pt_adv) begin
                     pt_last_in = cmd.now_ms;
                  end
                  status_in = dtbl_pkg::STATUS_PT_SHORT;
               end else begin
                  msg_milli_in = msg_take;
                  if (cmd.telemetry) begin
                     pt_milli_in = MW'(CW'(pt_refilled) - need_pt);
                     if (pt_adv) begin
                        pt_last_in = cmd.now_ms;
                     end
                  end
                  granted_in = 1'b1;
                  status_in  = dtbl_pkg::STATUS_GRANTED;
               end
            end
            dtbl_pkg::OP_REFUND: begin
               msg_milli_in = msg_refund;
            end
            dtbl_pkg::OP_RELOAD: begin
               msg_milli_in = cap_msg;
               pt_milli_in  = cap_pt;
               msg_last_in  = cmd.now_ms;
               pt_last_in   = cmd.now_ms;
            end
            default: begin
            end
         endcase
      end
   end

   // bucket state
   always_ff @(posedge clock) begin
      if (reset) begin
         msg_milli_ff <= MW'(dtbl_pkg::RESET_MSG_RATE * dtbl_pkg::MILLI);
         pt_milli_ff  <= MW'(dtbl_pkg::RESET_PT_RATE * dtbl_pkg::MILLI);
         msg_last_ff  <= '0;
         pt_last_ff   <= '0;
      end else if (pop) begin
         msg_milli_ff <= msg_milli_in;
         pt_milli_ff  <= pt_milli_in;
         msg_last_ff  <= msg_last_in;
         pt_last_ff   <= pt_last_in;
      end
   end

   // execute stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_granted_ff <= granted_in;
         s1_status_ff  <= status_in;
         s1_msg_ff     <= msg_milli_in;
         s1_pt_ff      <= pt_milli_in;
      end
   end

   // whole tokens through reciprocal multiply
   assign msg_div_in = dtbl_pkg::DIV_IN_BITS'(s1_msg_ff >> dtbl_pkg::DIV_PRE_SHIFT);
   assign pt_div_in  = dtbl_pkg::DIV_IN_BITS'(s1_pt_ff >> dtbl_pkg::DIV_PRE_SHIFT);
   assign msg_prod   = msg_div_in * dtbl_pkg::DIV_RECIP;
   assign pt_prod    = pt_div_in * dtbl_pkg::DIV_RECIP;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_granted_ff  <= s1_granted_ff;
         rsp_status_ff   <= s1_status_ff;
         rsp_msg_left_ff <= msg_prod[dtbl_pkg::DIV_SHIFT +: LW];
         rsp_pt_left_ff  <= pt_prod[dtbl_pkg::DIV_SHIFT +: LW];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_granted             = rsp_granted_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_message_tokens_left = rsp_msg_left_ff;
   assign rsp_point_tokens_left   = rsp_pt_left_ff;

   // reload stamps both buckets with the request time
   a_reload_time: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.op == dtbl_pkg::OP_RELOAD) |=>
         (msg_last_ff == $past(cmd.now_ms) && pt_last_ff == $past(cmd.now_ms)))
      else $error("reload did not set bucket times");

   // buckets move only when a word is taken from the queue
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !pop |=> ($stable(msg_milli_ff) && $stable(pt_milli_ff)))
      else $error("bucket changed without an operation");

   // a grant always carries the granted status
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_granted_ff) |-> s1_status_ff == dtbl_pkg::STATUS_GRANTED)
      else $error("grant with non-granted status");

   // execute stage holds its word while the output stage is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=>
         (s1_valid_ff && $stable(s1_msg_ff) && $stable(s1_pt_ff)))
      else $error("execute stage word lost under stall");

endmodule

`default_nettype wire

/* src/dual_token_bucket_limiter.sv */
// top level of the dual token bucket publish policer
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------------------
//  req_    | in        | req_valid / req_ready  | mode, now_ms, link, topic class, point count
//  rsp_    | out       | rsp_valid / rsp_ready  | granted, status, whole tokens left
//  csr_    | in        | csr_valid / csr_ready  | register index, write data
//
//  rate one word per cycle without rsp stalls; words pass queue, execute stage, output register
//  the combinational bucket update (clamp, refill multiply, cap, charge) sets the rate
//  reset: limiting on, rates 100 and 500, both buckets full, bucket times zero
//  a two-word queue sits between the front end and the engine; rsp stalls fill the
//  output register, then the execute stage, then the queue, then req_ready drops
//  csr_ready is always high; writes take effect at the next edge
`default_nettype none

module dual_token_bucket_limiter #(
   parameter int RATE_BITS = dtbl_pkg::RATE_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dtbl_pkg::MODE_BITS-1:0]        req_mode,
   input  wire logic [dtbl_pkg::TIME_BITS-1:0]        req_now_ms,
   input  wire logic                                  req_link_up,
   input  wire logic                                  req_limited_topic,
   input  wire logic                                  req_telemetry_topic,
   input  wire logic [dtbl_pkg::COUNT_BITS-1:0]       req_point_count,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_granted,
   output logic [dtbl_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [dtbl_pkg::LEFT_BITS-1:0]             rsp_message_tokens_left,
   output logic [dtbl_pkg::LEFT_BITS-1:0]             rsp_point_tokens_left,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [dtbl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [RATE_BITS-1:0]                  csr_wdata
);

   // configuration registers
   logic                  limiting_en_ff;
   logic [RATE_BITS-1:0]  msg_rate_ff;
   logic [RATE_BITS-1:0]  pt_rate_ff;

   // front to queue to engine
   logic               push;
   logic               queue_full;
   logic               pop;
   logic               q_valid;
   dtbl_pkg::cmd_type  push_cmd;
   dtbl_pkg::cmd_type  q_cmd;

   assign csr_ready = 1'b1;

   // register writes; an unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         limiting_en_ff <= 1'b1;
         msg_rate_ff    <= RATE_BITS'(dtbl_pkg::RESET_MSG_RATE);
         pt_rate_ff     <= RATE_BITS'(dtbl_pkg::RESET_PT_RATE);
      end else if (csr_valid) begin
         unique case (csr_index)
            dtbl_pkg::CSR_LIMITING: limiting_en_ff <= csr_wdata[0];
            dtbl_pkg::CSR_MSG_RATE: msg_rate_ff    <= csr_wdata;
            dtbl_pkg::CSR_PT_RATE:  pt_rate_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // classify the request against the limiting setting
   dtbl_front u_front (
      .limiting_enabled    (limiting_en_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_now_ms          (req_now_ms),
      .req_link_up         (req_link_up),
      .req_limited_topic   (req_limited_topic),
      .req_telemetry_topic (req_telemetry_topic),
      .req_point_count     (req_point_count),
      .queue_full          (queue_full),
      .push                (push),
      .cmd                 (push_cmd)
   );

   // decouples acceptance from the engine
   dtbl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   // bucket update and result path
   dtbl_engine #(
      .RATE_BITS (RATE_BITS)
   ) u_engine (
      .clock                   (clock),
      .reset                   (reset),
      .msg_rate                (msg_rate_ff),
      .pt_rate                 (pt_rate_ff),
      .q_valid                 (q_valid),
      .cmd                     (q_cmd),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_granted             (rsp_granted),
      .rsp_status              (rsp_status),
      .rsp_message_tokens_left (rsp_message_tokens_left),
      .rsp_point_tokens_left   (rsp_point_tokens_left)
   );

endmodule

`default_nettype wire

/* tb/token_policer_monitor.sv */
// monitor that predicts each policer result from the accepted words and compares it
`timescale 1ns / 1ps

module token_policer_monitor (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         req_valid,
   input  wire logic                                         req_ready,
   input  wire logic [dtbl_pkg::MODE_BITS-1:0]               req_mode,
   input  wire logic [dtbl_pkg::TIME_BITS-1:0]               req_now_ms,
   input  wire logic                                         req_link_up,
   input  wire logic                                         req_limited_topic,
   input  wire logic                                         req_telemetry_topic,
   input  wire logic [dtbl_pkg::COUNT_BITS-1:0]              req_point_count,
   input  wire logic                                         rsp_valid,
   input  wire logic                                         rsp_ready,
   input  wire logic                                         rsp_granted,
   input  wire logic [dtbl_pkg::STATUS_BITS-1:0]             rsp_status,
   input  wire logic [dtbl_pkg::LEFT_BITS-1:0]               rsp_message_tokens_left,
   input  wire logic [dtbl_pkg::LEFT_BITS-1:0]               rsp_point_tokens_left,
   input  wire logic                                         csr_valid,
   input  wire logic                                         csr_ready,
   input  wire logic [dtbl_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  wire logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0]       csr_wdata,
   output int                                                mismatches,
   output int                                                words_pending,
   output int                                                words_checked
);

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic                             granted;
      logic [dtbl_pkg::STATUS_BITS-1:0] status;
      logic [dtbl_pkg::LEFT_BITS-1:0]   msg_left;
      logic [dtbl_pkg::LEFT_BITS-1:0]   pt_left;
   } outcome_type;

   logic                                   limit_on;
   logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] msg_rate;
   logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] pt_rate;
   logic [63:0]                            msg_milli;
   logic [63:0]                            pt_milli;
   logic [dtbl_pkg::TIME_BITS-1:0]         msg_stamp;
   logic [dtbl_pkg::TIME_BITS-1:0]         pt_stamp;
   outcome_type                            due_outcomes[$];

   // refill from the time gap (at most one second), capped at a full bucket only when time advanced
   function automatic logic [63:0] topped_up(input logic [63:0] milli,
                                             input logic [31:0] stamp,
                                             input logic [63:0] rate,
                                             input logic [31:0] now);
      logic [63:0] gap;
      logic [63:0] sum;
      if (now <= stamp)
         return milli;
      gap = 64'(now - stamp);
      if (gap > 64'(dtbl_pkg::MAX_ELAPSED_MS))
         gap = 64'(dtbl_pkg::MAX_ELAPSED_MS);
      sum = milli + gap * rate;
      if (sum > rate * 64'(dtbl_pkg::MILLI))
         sum = rate * 64'(dtbl_pkg::MILLI);
      return sum;
   endfunction

   function automatic logic [63:0] token_back(input logic [63:0] milli,
                                              input logic [63:0] rate);
      logic [63:0] sum;
      sum = milli + 64'(dtbl_pkg::MILLI);
      return (sum > rate * 64'(dtbl_pkg::MILLI)) ? rate * 64'(dtbl_pkg::MILLI) : sum;
   endfunction

   function automatic outcome_type police(input logic [dtbl_pkg::MODE_BITS-1:0]  mode,
                                          input logic [dtbl_pkg::TIME_BITS-1:0]  now,
                                          input logic                            link,
                                          input logic                            limited,
                                          input logic                            telem,
                                          input logic [dtbl_pkg::COUNT_BITS-1:0] points);
      outcome_type res;
      logic        active;
      logic [63:0] need;
      res.granted = 1'b0;
      res.status  = dtbl_pkg::STATUS_DONE;
      active      = limit_on && limited;
      case (mode)
         dtbl_pkg::MODE_SEND: begin
            if (!link) begin
               res.status = dtbl_pkg::STATUS_NO_LINK;
            end else if (!active) begin
               res.granted = 1'b1;
               res.status  = dtbl_pkg::STATUS_GRANTED;
            end else begin
               msg_milli = topped_up(msg_milli, msg_stamp, 64'(msg_rate), now);
               if (now > msg_stamp)
                  msg_stamp = now;
               if (msg_milli < 64'(dtbl_pkg::MILLI)) begin
                  res.status = dtbl_pkg::STATUS_MSG_SHORT;
               end else begin
                  msg_milli = msg_milli - 64'(dtbl_pkg::MILLI);
                  res.granted = 1'b1;
                  res.status  = dtbl_pkg::STATUS_GRANTED;
                  if (telem) begin
                     need     = 64'(points) * 64'(dtbl_pkg::MILLI);
                     pt_milli = topped_up(pt_milli, pt_stamp, 64'(pt_rate), now);
                     if (now > pt_stamp)
                        pt_stamp = now;
                     if (pt_milli < need) begin
                        msg_milli   = token_back(msg_milli, 64'(msg_rate));
                        res.granted = 1'b0;
                        res.status  = dtbl_pkg::STATUS_PT_SHORT;
                     end else begin
                        pt_milli = pt_milli - need;
                     end
                  end
               end
            end
         end
         dtbl_pkg::MODE_REFUND: begin
            if (active)
               msg_milli = token_back(msg_milli, 64'(msg_rate));
         end
         dtbl_pkg::MODE_RELOAD: begin
            msg_milli = 64'(msg_rate) * 64'(dtbl_pkg::MILLI);
            pt_milli  = 64'(pt_rate) * 64'(dtbl_pkg::MILLI);
            msg_stamp = now;
            pt_stamp  = now;
         end
         default: ;
      endcase
      res.msg_left = dtbl_pkg::LEFT_BITS'(msg_milli / 64'(dtbl_pkg::MILLI));
      res.pt_left  = dtbl_pkg::LEFT_BITS'(pt_milli / 64'(dtbl_pkg::MILLI));
      return res;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t: %s is %0d, predicted %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         limit_on  = 1'b1;
         msg_rate  = dtbl_pkg::RATE_BITS_DEFAULT'(dtbl_pkg::RESET_MSG_RATE);
         pt_rate   = dtbl_pkg::RATE_BITS_DEFAULT'(dtbl_pkg::RESET_PT_RATE);
         msg_milli = 64'(dtbl_pkg::RESET_MSG_RATE) * 64'(dtbl_pkg::MILLI);
         pt_milli  = 64'(dtbl_pkg::RESET_PT_RATE) * 64'(dtbl_pkg::MILLI);
         msg_stamp = '0;
         pt_stamp  = '0;
         due_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_granted, rsp_status, rsp_message_tokens_left, rsp_point_tokens_left};
            if (due_outcomes.size() == 0) begin
               report("result word with nothing awaited, status", 32'(seen.status),
                      32'(dtbl_pkg::STATUS_DONE));
            end else begin
               want = due_outcomes.pop_front();
               if (seen.granted !== want.granted)
                  report("granted", 32'(seen.granted), 32'(want.granted));
               if (seen.status !== want.status)
                  report("status", 32'(seen.status), 32'(want.status));
               if (seen.msg_left !== want.msg_left)
                  report("message tokens left", 32'(seen.msg_left), 32'(want.msg_left));
               if (seen.pt_left !== want.pt_left)
                  report("datapoint tokens left", 32'(seen.pt_left), 32'(want.pt_left));
               words_checked++;
            end
         end
         // a word taken at the same edge as a register write still sees the old setting
         if (req_valid && req_ready)
            due_outcomes.push_back(police(req_mode, req_now_ms, req_link_up,
                                          req_limited_topic, req_telemetry_topic,
                                          req_point_count));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dtbl_pkg::CSR_LIMITING: limit_on = csr_wdata[0];
               dtbl_pkg::CSR_MSG_RATE: msg_rate = csr_wdata;
               dtbl_pkg::CSR_PT_RATE:  pt_rate  = csr_wdata;
               default: ;
            endcase
         end
      end
      words_pending <= due_outcomes.size();
   end

endmodule

/* tb/dual_token_bucket_limiter_test.sv */
// stimulus, receiver stalls and verdict for the dual token bucket limiter
`timescale 1ns / 1ps

module dual_token_bucket_limiter_test;

   localparam int RESET_CYCLES    = 9;
   localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
   localparam int STALL_LIMIT     = 2000;  // quiet cycles before the run is called hung
   localparam int DRAIN_CYCLES    = 4;     // margin after the last awaited result returns
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 150;
   localparam int HOLD_PHASE      = 5;

   localparam logic [dtbl_pkg::MODE_BITS-1:0]         MODE_UNUSED = 2'd3;
   localparam logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] RATE_MAX    = '1;

   logic                                    clock = 1'b0;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_ready;
   logic [dtbl_pkg::MODE_BITS-1:0]          req_mode;
   logic [dtbl_pkg::TIME_BITS-1:0]          req_now_ms;
   logic                                    req_link_up;
   logic                                    req_limited_topic;
   logic                                    req_telemetry_topic;
   logic [dtbl_pkg::COUNT_BITS-1:0]         req_point_count;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic                                    rsp_granted;
   logic [dtbl_pkg::STATUS_BITS-1:0]        rsp_status;
   logic [dtbl_pkg::LEFT_BITS-1:0]          rsp_message_tokens_left;
   logic [dtbl_pkg::LEFT_BITS-1:0]          rsp_point_tokens_left;
   logic                                    csr_valid;
   logic                                    csr_ready;
   logic [dtbl_pkg::CSR_INDEX_BITS-1:0]     csr_index;
   logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0]  csr_wdata;

   int                                      mismatches;
   int                                      words_pending;
   int                                      words_checked;

   // sender bookkeeping
   logic [dtbl_pkg::TIME_BITS-1:0]          now_track;
   int unsigned                             step_max;
   logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0]  rate_p;
   bit                                      sender_idling;
   int                                      words_sent;
   int                                      settings_made;

   // receiver control
   logic                                    sink_idling = 1'b0;
   bit                                      hold_go = 1'b0;
   logic                                    hold_rsp = 1'b0;
   int                                      stall_left = 0;
   int                                      quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dual_token_bucket_limiter uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_mode                (req_mode),
      .req_now_ms              (req_now_ms),
      .req_link_up             (req_link_up),
      .req_limited_topic       (req_limited_topic),
      .req_telemetry_topic     (req_telemetry_topic),
      .req_point_count         (req_point_count),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_granted             (rsp_granted),
      .rsp_status              (rsp_status),
      .rsp_message_tokens_left (rsp_message_tokens_left),
      .rsp_point_tokens_left   (rsp_point_tokens_left),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   token_policer_monitor monitor (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_mode                (req_mode),
      .req_now_ms              (req_now_ms),
      .req_link_up             (req_link_up),
      .req_limited_topic       (req_limited_topic),
      .req_telemetry_topic     (req_telemetry_topic),
      .req_point_count         (req_point_count),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_granted             (rsp_granted),
      .rsp_status              (rsp_status),
      .rsp_message_tokens_left (rsp_message_tokens_left),
      .rsp_point_tokens_left   (rsp_point_tokens_left),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .mismatches              (mismatches),
      .words_pending           (words_pending),
      .words_checked           (words_checked)
   );

   // receiver: random stall bursts, overridden by the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sink_idling && $urandom_range(0, 11) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long hold-off, counted here while the sender keeps offering words
   initial begin : hold_off
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // hang detector: any handshake on any channel clears the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("dual_token_bucket_limiter: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one word and hold it until taken; maybe idle afterwards
   task automatic send_word(input logic [dtbl_pkg::MODE_BITS-1:0]  mode,
                            input logic [dtbl_pkg::TIME_BITS-1:0]  now,
                            input logic                            link,
                            input logic                            limited,
                            input logic                            telem,
                            input logic [dtbl_pkg::COUNT_BITS-1:0] points);
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_now_ms          <= now;
      req_link_up         <= link;
      req_limited_topic   <= limited;
      req_telemetry_topic <= telem;
      req_point_count     <= points;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
      if (sender_idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(input logic [dtbl_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_regs(input logic en,
                           input logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] mr,
                           input logic [dtbl_pkg::RATE_BITS_DEFAULT-1:0] pr);
      quiesce();
      // junk in the upper bits of the enable write must be ignored
      write_reg(dtbl_pkg::CSR_LIMITING,
                (dtbl_pkg::RATE_BITS_DEFAULT'($urandom()) &
                 ~dtbl_pkg::RATE_BITS_DEFAULT'(1)) | dtbl_pkg::RATE_BITS_DEFAULT'(en));
      write_reg(dtbl_pkg::CSR_MSG_RATE, mr);
      write_reg(dtbl_pkg::CSR_PT_RATE, pr);
      csr_valid <= 1'b0;
      rate_p = pr;
      settings_made++;
   endtask

   // mostly limited, connected sends with a clock that creeps forward;
   // now and then jumps, steps back, wraps, refunds, reloads and unused modes
   task automatic random_word();
      int unsigned                     pick;
      int unsigned                     lim;
      logic [dtbl_pkg::MODE_BITS-1:0]  mode;
      logic [dtbl_pkg::COUNT_BITS-1:0] points;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         now_track = $urandom();
      else if (pick < 6)
         now_track = now_track - $urandom_range(1, 50);
      else if (pick < 9)
         now_track = now_track + $urandom_range(1000, 5000);
      else
         now_track = now_track + $urandom_range(0, step_max);
      pick = $urandom_range(0, 99);
      if (pick < 82)
         mode = dtbl_pkg::MODE_SEND;
      else if (pick < 92)
         mode = dtbl_pkg::MODE_REFUND;
      else if (pick < 96)
         mode = dtbl_pkg::MODE_RELOAD;
      else
         mode = MODE_UNUSED;
      // point counts sized to the datapoint bucket so both outcomes turn up
      lim  = (rate_p > 8190) ? 32'd4095 : 32'(rate_p) / 32'd2 + 32'd1;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         points = dtbl_pkg::COUNT_BITS'($urandom_range(0, lim));
      else if (pick < 9)
         points = dtbl_pkg::COUNT_BITS'($urandom_range(0, 3));
      else
         points = dtbl_pkg::COUNT_BITS'($urandom());
      send_word(mode, now_track, $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 88,
                1'($urandom_range(0, 1)), points);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_mode            <= dtbl_pkg::MODE_SEND;
      req_now_ms          <= '0;
      req_link_up         <= 1'b0;
      req_limited_topic   <= 1'b0;
      req_telemetry_topic <= 1'b0;
      req_point_count     <= '0;
      csr_valid           <= 1'b0;
      csr_index           <= dtbl_pkg::CSR_LIMITING;
      csr_wdata           <= '0;
      sink_idling         <= 1'b1;
      sender_idling = 1'b0;
      now_track     = '0;
      step_max      = 20;
      rate_p        = dtbl_pkg::RATE_BITS_DEFAULT'(dtbl_pkg::RESET_PT_RATE);
      words_sent    = 0;
      settings_made = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset rates 100 and 500 with limiting on
      // one message token from a full bucket, clock not moved
      send_word(dtbl_pkg::MODE_SEND, 32'd0, 1'b1, 1'b1, 1'b0, 12'd0);
      // link down is refused and changes nothing
      send_word(dtbl_pkg::MODE_SEND, 32'd0, 1'b0, 1'b1, 1'b1, 12'd5);
      // unlimited topic passes even as telemetry
      send_word(dtbl_pkg::MODE_SEND, 32'd0, 1'b1, 1'b0, 1'b1, 12'hFFF);
      // datapoints short: the message token goes back
      send_word(dtbl_pkg::MODE_SEND, 32'd5, 1'b1, 1'b1, 1'b1, 12'hFFF);
      // zero datapoints always meet the datapoint bucket
      send_word(dtbl_pkg::MODE_SEND, 32'd5, 1'b1, 1'b1, 1'b1, 12'd0);
      // empty the datapoint bucket exactly
      send_word(dtbl_pkg::MODE_SEND, 32'd5, 1'b1, 1'b1, 1'b1, 12'd500);
      // a millisecond later only half a datapoint token has come back
      send_word(dtbl_pkg::MODE_SEND, 32'd6, 1'b1, 1'b1, 1'b1, 12'd1);
      // refund acts on a limited topic only
      send_word(dtbl_pkg::MODE_REFUND, 32'd6, 1'b1, 1'b1, 1'b0, 12'd0);
      send_word(dtbl_pkg::MODE_REFUND, 32'd6, 1'b1, 1'b0, 1'b0, 12'd0);
      send_word(MODE_UNUSED, 32'd6, 1'b1, 1'b1, 1'b1, 12'd1);
      // reload near the top of the clock, step to its last value, then wrap
      send_word(dtbl_pkg::MODE_RELOAD, 32'hFFFF_FF00, 1'b1, 1'b1, 1'b1, 12'd1);
      send_word(dtbl_pkg::MODE_SEND, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 12'd7);
      send_word(dtbl_pkg::MODE_SEND, 32'd10, 1'b1, 1'b1, 1'b1, 12'd7);

      // smaller rates leave the fuller bucket alone until something caps it
      set_regs(1'b1, 20'd2, 20'd3);
      send_word(dtbl_pkg::MODE_SEND, 32'd10, 1'b1, 1'b1, 1'b0, 12'd0);
      send_word(dtbl_pkg::MODE_RELOAD, 32'd20, 1'b1, 1'b1, 1'b0, 12'd0);
      // two-token bucket: the third send in the same millisecond is short
      send_word(dtbl_pkg::MODE_SEND, 32'd20, 1'b1, 1'b1, 1'b0, 12'd0);
      send_word(dtbl_pkg::MODE_SEND, 32'd20, 1'b1, 1'b1, 1'b0, 12'd0);
      send_word(dtbl_pkg::MODE_SEND, 32'd20, 1'b1, 1'b1, 1'b0, 12'd0);
      // long gap refills only up to capacity
      send_word(dtbl_pkg::MODE_SEND, 32'd2000, 1'b1, 1'b1, 1'b1, 12'd3);

      // limiting off: everything connected passes, refunds do nothing
      set_regs(1'b0, 20'd2, 20'd3);
      send_word(dtbl_pkg::MODE_SEND, 32'd2001, 1'b1, 1'b1, 1'b1, 12'hFFF);
      send_word(dtbl_pkg::MODE_REFUND, 32'd2001, 1'b1, 1'b1, 1'b0, 12'd0);

      // full-scale message rate, zero datapoint rate
      set_regs(1'b1, RATE_MAX, 20'd0);
      send_word(dtbl_pkg::MODE_RELOAD, 32'd3000, 1'b1, 1'b1, 1'b1, 12'd0);
      send_word(dtbl_pkg::MODE_SEND, 32'd3000, 1'b1, 1'b1, 1'b1, 12'd1);
      send_word(dtbl_pkg::MODE_SEND, 32'd3001, 1'b1, 1'b1, 1'b1, 12'd0);

      // random part, one register setting per phase
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               set_regs(1'b1, dtbl_pkg::RATE_BITS_DEFAULT'(dtbl_pkg::RESET_MSG_RATE),
                        dtbl_pkg::RATE_BITS_DEFAULT'(dtbl_pkg::RESET_PT_RATE));
               step_max = 20;
            end
            1: begin
               set_regs(1'b1, 20'd1, 20'd1);
               step_max = 60;
            end
            2: begin
               set_regs(1'b1, RATE_MAX, RATE_MAX);
               step_max = 3;
            end
            3: begin
               set_regs(1'b0, dtbl_pkg::RATE_BITS_DEFAULT'($urandom()),
                        dtbl_pkg::RATE_BITS_DEFAULT'($urandom()));
               step_max = 30;
            end
            4: begin
               set_regs(1'b1, 20'd0, 20'd0);
               step_max = 30;
            end
            default: begin
               set_regs($urandom_range(0, 5) != 0,
                        dtbl_pkg::RATE_BITS_DEFAULT'($urandom_range(1, 30)),
                        dtbl_pkg::RATE_BITS_DEFAULT'($urandom_range(1, 300)));
               step_max = $urandom_range(0, 60);
            end
         endcase
         // no idling in the full-scale phase and in the closing phase
         sender_idling = (phase != 2) && (phase != PHASES - 1);
         sink_idling  <= (phase != 2) && (phase != PHASES - 1);
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase == HOLD_PHASE && n == 20)
               hold_go = 1'b1;
            random_word();
         end
      end

      quiesce();
      $display("covered %0d request words across %0d register settings, %0d results compared",
               words_sent, settings_made, words_checked);
      $display("incl. clock wrap and step-back, zero and full-scale rates, a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("dual_token_bucket_limiter: match");
      else
         $display("dual_token_bucket_limiter: mismatch");
      $finish;
   end

endmodule
